FILE: hw/rtl/drpq_pkg.sv
// ----------------------------------------------------------------------------
// drpq_pkg
// Types and constants shared by the dual priority request queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drpq_pkg;

    localparam int unsigned AllowWidth = 6;
    localparam int unsigned CountWidth = 16;
    localparam logic [AllowWidth-1:0] AllowReset = 6'd32;

    typedef enum logic [1:0] {
        K_ENQUEUE = 2'd0,
        K_DEQUEUE = 2'd1,
        K_PURGE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ
    } t_state;

    // One stored request.
    typedef struct packed {
        logic [2:0]  special_op;
        logic [15:0] bus_addr;
        logic [7:0]  offset;
        logic [5:0]  reg_num;
        logic [6:0]  func_code;
        logic [6:0]  word_count;
        logic [31:0] write_data;
        logic [31:0] requester_tag;
    } t_entry;

    // Command from the controller to one queue.
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;      // purge without counting
        logic pre_flush;  // counted flush ahead of a push
    } t_q_cmd;

    typedef struct packed {
        logic                  found;
        logic                  from_high;
        t_entry                entry;
        logic [CountWidth-1:0] low_purges;
        logic [CountWidth-1:0] high_purges;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/drpq_in_if.sv
// ----------------------------------------------------------------------------
// drpq_in_if
// Request channel: enqueue, dequeue and purge words.
// ----------------------------------------------------------------------------
`default_nettype none

interface drpq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        priority_req;
    logic [2:0]  special_op;
    logic [15:0] start_addr;
    logic [7:0]  channel;
    logic [7:0]  stride;
    logic [7:0]  offset;
    logic [5:0]  reg_num;
    logic [6:0]  func_code;
    logic [6:0]  word_count;
    logic [31:0] write_data;
    logic [31:0] requester_tag;

    modport source (
        output valid, kind, priority_req, special_op, start_addr, channel, stride,
               offset, reg_num, func_code, word_count, write_data, requester_tag,
        input  ready
    );
    modport sink (
        input  valid, kind, priority_req, special_op, start_addr, channel, stride,
               offset, reg_num, func_code, word_count, write_data, requester_tag,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/drpq_out_if.sv
// ----------------------------------------------------------------------------
// drpq_out_if
// Response channel: one word for each dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

interface drpq_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        from_high;
    logic [2:0]  out_special_op;
    logic [15:0] bus_addr;
    logic [7:0]  out_offset;
    logic [5:0]  out_reg_num;
    logic [6:0]  out_func_code;
    logic [6:0]  out_word_count;
    logic [31:0] out_write_data;
    logic [31:0] out_requester_tag;
    logic [15:0] low_purges;
    logic [15:0] high_purges;

    modport source (
        output valid, found, from_high, out_special_op, bus_addr, out_offset,
               out_reg_num, out_func_code, out_word_count, out_write_data,
               out_requester_tag, low_purges, high_purges,
        input  ready
    );
    modport sink (
        input  valid, found, from_high, out_special_op, bus_addr, out_offset,
               out_reg_num, out_func_code, out_word_count, out_write_data,
               out_requester_tag, low_purges, high_purges,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/drpq_cfg_if.sv
// ----------------------------------------------------------------------------
// drpq_cfg_if
// Configuration write channel for the low queue allowance.
// ----------------------------------------------------------------------------
`default_nettype none

interface drpq_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/drpq_fifo.sv
// ----------------------------------------------------------------------------
// drpq_fifo
// One request queue: entry memory, head pointer, fill count, flush counter.
// ----------------------------------------------------------------------------
`default_nettype none

module drpq_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  drpq_pkg::t_q_cmd                  i_cmd,
    input  drpq_pkg::t_entry                  i_entry,
    output drpq_pkg::t_entry                  o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]        o_fill,
    output logic [drpq_pkg::CountWidth-1:0]   o_purges
);
    import drpq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW = $clog2(DEPTH+1);
    localparam int unsigned SW = ((AW > FW) ? AW : FW) + 1;

    t_entry           r_mem [DEPTH];
    t_entry           r_rdata;
    logic [AW-1:0]    r_head, n_head;
    logic [FW-1:0]    r_fill, n_fill;
    logic [CountWidth-1:0] r_purges, n_purges;

    logic [AW-1:0]    head_a, head_b, wr_addr;
    logic [FW-1:0]    fill_a, fill_b;
    logic             full;
    logic [SW-1:0]    pos_sum;

    always_comb begin
        head_a = (i_cmd.flush || i_cmd.pre_flush) ? '0 : r_head;
        fill_a = (i_cmd.flush || i_cmd.pre_flush) ? '0 : r_fill;
        full   = (fill_a == FW'(DEPTH));
        head_b = full ? '0 : head_a;
        fill_b = full ? '0 : fill_a;
        // The sum stays below twice the depth, so one subtract wraps it.
        pos_sum = SW'(head_b) + SW'(fill_b);
        if (pos_sum >= SW'(DEPTH)) begin
            pos_sum = pos_sum - SW'(DEPTH);
        end
        wr_addr = pos_sum[AW-1:0];

        n_head   = r_head;
        n_fill   = r_fill;
        n_purges = r_purges;
        if (i_cmd.push) begin
            n_head = head_b;
            n_fill = fill_b + FW'(1);
            if (i_cmd.pre_flush || full) begin
                n_purges = r_purges + CountWidth'(1);
            end
        end else if (i_cmd.pop) begin
            n_head = (r_head == AW'(DEPTH-1)) ? '0 : r_head + AW'(1);
            n_fill = r_fill - FW'(1);
        end else if (i_cmd.flush) begin
            n_head = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_entry;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_purges <= '0;
        end else begin
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_purges <= n_purges;
        end
    end

    assign o_rdata  = r_rdata;
    assign o_fill   = r_fill;
    assign o_purges = r_purges;

endmodule

`default_nettype wire

FILE: hw/rtl/drpq_ctrl.sv
// ----------------------------------------------------------------------------
// drpq_ctrl
// Sequencer: takes request words, drives the two queues, holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module drpq_ctrl #(
    parameter int unsigned HIGH_DEPTH = 16,
    parameter int unsigned LOW_DEPTH  = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    drpq_in_if.sink                              i_req,
    drpq_out_if.source                           o_rsp,
    drpq_cfg_if.sink                             i_cfg,
    output drpq_pkg::t_q_cmd                     o_high_cmd,
    output drpq_pkg::t_q_cmd                     o_low_cmd,
    output drpq_pkg::t_entry                     o_entry,
    input  drpq_pkg::t_entry                     i_high_rdata,
    input  drpq_pkg::t_entry                     i_low_rdata,
    input  wire logic [$clog2(HIGH_DEPTH+1)-1:0] i_high_fill,
    input  wire logic [$clog2(LOW_DEPTH+1)-1:0]  i_low_fill,
    input  wire logic [drpq_pkg::CountWidth-1:0] i_low_purges,
    input  wire logic [drpq_pkg::CountWidth-1:0] i_high_purges
);
    import drpq_pkg::*;

    t_state               r_state, n_state;
    logic [AllowWidth-1:0] r_allow;
    t_entry               r_item;
    logic [15:0]          r_start;
    logic [15:0]          r_prod;
    logic                 r_hi;
    logic                 r_found;
    logic                 r_from_high;
    t_result              r_out;
    logic                 r_out_valid;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    t_kind                kind;
    t_result              rsp;

    assign kind     = t_kind'(i_req.kind);
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign load_out = (r_state == S_DEQ) && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && kind == K_ENQUEUE) begin
                    n_state = S_ENQ;
                end else if (accept && kind == K_DEQUEUE) begin
                    n_state = S_DEQ;
                end
            end
            S_ENQ: begin
                n_state = S_IDLE;
            end
            S_DEQ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs to the handshake and the queues.
    always_comb begin
        i_req.ready = 1'b0;
        o_high_cmd  = '0;
        o_low_cmd   = '0;
        o_entry     = r_item;
        o_entry.bus_addr = r_start + r_prod + 16'(r_item.offset);
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept && kind == K_DEQUEUE) begin
                    if (i_high_fill != '0) begin
                        o_high_cmd.pop = 1'b1;
                    end else if (i_low_fill != '0) begin
                        o_low_cmd.pop = 1'b1;
                    end
                end else if (accept && kind == K_PURGE) begin
                    if (i_req.priority_req) begin
                        o_high_cmd.flush = 1'b1;
                    end else begin
                        o_low_cmd.flush = 1'b1;
                    end
                end
            end
            S_ENQ: begin
                if (r_hi) begin
                    o_high_cmd.push = 1'b1;
                end else begin
                    o_low_cmd.push      = 1'b1;
                    o_low_cmd.pre_flush = (32'(i_low_fill) >= 32'(r_allow));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rsp.found       = r_found;
        rsp.from_high   = r_from_high;
        rsp.entry       = '0;
        if (r_found) begin
            rsp.entry = r_from_high ? i_high_rdata : i_low_rdata;
        end
        rsp.low_purges  = i_low_purges;
        rsp.high_purges = i_high_purges;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_allow     <= AllowReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_allow <= i_cfg.data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.special_op    <= i_req.special_op;
            r_item.bus_addr      <= '0;
            r_item.offset        <= i_req.offset;
            r_item.reg_num       <= i_req.reg_num;
            r_item.func_code     <= i_req.func_code;
            r_item.word_count    <= i_req.word_count;
            r_item.write_data    <= i_req.write_data;
            r_item.requester_tag <= i_req.requester_tag;
            r_start              <= i_req.start_addr;
            r_prod               <= 16'(i_req.stride) * 16'(i_req.channel);
            r_hi                 <= i_req.priority_req;
            r_found              <= (i_high_fill != '0) || (i_low_fill != '0);
            r_from_high          <= (i_high_fill != '0);
        end
        if (load_out) begin
            r_out <= rsp;
        end
    end

    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.found             = r_out.found;
    assign o_rsp.from_high         = r_out.from_high;
    assign o_rsp.out_special_op    = r_out.entry.special_op;
    assign o_rsp.bus_addr          = r_out.entry.bus_addr;
    assign o_rsp.out_offset        = r_out.entry.offset;
    assign o_rsp.out_reg_num       = r_out.entry.reg_num;
    assign o_rsp.out_func_code     = r_out.entry.func_code;
    assign o_rsp.out_word_count    = r_out.entry.word_count;
    assign o_rsp.out_write_data    = r_out.entry.write_data;
    assign o_rsp.out_requester_tag = r_out.entry.requester_tag;
    assign o_rsp.low_purges        = r_out.low_purges;
    assign o_rsp.high_purges       = r_out.high_purges;

endmodule

`default_nettype wire

FILE: hw/rtl/dual_priority_request_queue_unit.sv
// ----------------------------------------------------------------------------
// dual_priority_request_queue_unit
// Strict two-level priority request queue with flush and purge counters.
// ----------------------------------------------------------------------------
//
//   Port     Dir  Word
//   i_req    in   enqueue / dequeue / purge request
//   o_rsp    out  dequeued entry or empty indication, with purge counts
//   i_cfg    in   low queue allowance, always ready
//
// An enqueue registers the stride product, then sums the address and writes
// the entry into the queue memory. A dequeue pops the queue into its read
// register, then loads the response register, waiting while a previous word
// has not been taken. A purge acts as soon as its word is accepted.
// Reset clears pointers, fill counts and counters; the memories need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_priority_request_queue_unit #(
    parameter int unsigned HIGH_DEPTH = 16,
    parameter int unsigned LOW_DEPTH  = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    drpq_in_if.sink     i_req,
    drpq_out_if.source  o_rsp,
    drpq_cfg_if.sink    i_cfg
);
    import drpq_pkg::*;

    t_q_cmd high_cmd;
    t_q_cmd low_cmd;
    t_entry entry;
    t_entry high_rdata;
    t_entry low_rdata;
    logic [$clog2(HIGH_DEPTH+1)-1:0] high_fill;
    logic [$clog2(LOW_DEPTH+1)-1:0]  low_fill;
    logic [CountWidth-1:0]           high_purges;
    logic [CountWidth-1:0]           low_purges;

    drpq_fifo #(.DEPTH(HIGH_DEPTH)) u_high (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (high_cmd),
        .i_entry  (entry),
        .o_rdata  (high_rdata),
        .o_fill   (high_fill),
        .o_purges (high_purges)
    );

    drpq_fifo #(.DEPTH(LOW_DEPTH)) u_low (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (low_cmd),
        .i_entry  (entry),
        .o_rdata  (low_rdata),
        .o_fill   (low_fill),
        .o_purges (low_purges)
    );

    drpq_ctrl #(
        .HIGH_DEPTH (HIGH_DEPTH),
        .LOW_DEPTH  (LOW_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .i_cfg         (i_cfg),
        .o_high_cmd    (high_cmd),
        .o_low_cmd     (low_cmd),
        .o_entry       (entry),
        .i_high_rdata  (high_rdata),
        .i_low_rdata   (low_rdata),
        .i_high_fill   (high_fill),
        .i_low_fill    (low_fill),
        .i_low_purges  (low_purges),
        .i_high_purges (high_purges)
    );

endmodule

`default_nettype wire

FILE: bench/dual_priority_request_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_priority_request_queue_unit_tb
// Self-checking bench for the two-level priority request queue. A driver
// feeds enqueue, dequeue and purge words from a queue, and a monitor checks
// every response word against a behavioral copy of both queues and of the
// purge counters. The run covers several low queue allowance settings and
// full queue flushes.
// ----------------------------------------------------------------------------
module dual_priority_request_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drpq_pkg::*;

    localparam int HighDepth    = 16;
    localparam int LowDepth     = 32;
    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 165;
    localparam int CycleLimit   = 200000;
    localparam logic [1:0] KindUnused = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        prio;
        logic [2:0]  special_op;
        logic [15:0] start_addr;
        logic [7:0]  channel;
        logic [7:0]  stride;
        logic [7:0]  offset;
        logic [5:0]  reg_num;
        logic [6:0]  func_code;
        logic [6:0]  word_count;
        logic [31:0] write_data;
        logic [31:0] requester_tag;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    drpq_in_if  req_if ();
    drpq_out_if rsp_if ();
    drpq_cfg_if cfg_if ();

    dual_priority_request_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Behavioral copy of the queues.
    t_entry      high_slots [HighDepth];
    t_entry      low_slots [LowDepth];
    int          high_head, high_fill, low_head, low_fill;
    logic [15:0] low_flushes, high_flushes;
    logic [5:0]  low_allowance;

    t_request pending_requests [$];
    t_result  expected_responses [$];
    t_request driven_request;
    t_result  next_response;

    bit req_busy;
    int req_wait, rsp_wait;
    int req_calm, rsp_calm;
    int error_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic t_request make_request(input logic [1:0] kind, input logic prio);
        t_request r;
        r.kind          = kind;
        r.prio          = prio;
        r.special_op    = 3'($urandom_range(0, 7));
        r.start_addr    = 16'($urandom_range(0, 16'hFFFF));
        r.channel       = 8'($urandom_range(0, 255));
        r.stride        = 8'($urandom_range(0, 255));
        r.offset        = 8'($urandom_range(0, 255));
        r.reg_num       = 6'($urandom_range(0, 63));
        r.func_code     = 7'($urandom_range(0, 127));
        r.word_count    = 7'($urandom_range(0, 125));
        r.write_data    = $urandom();
        r.requester_tag = $urandom();
        // Now and then pin the address terms at their extremes.
        case ($urandom_range(0, 9))
            0: begin
                r.start_addr = '0;
                r.channel    = '0;
                r.stride     = '0;
                r.offset     = '0;
            end
            1: begin
                r.start_addr = '1;
                r.channel    = '1;
                r.stride     = '1;
                r.offset     = '1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Applies one accepted request word to the queue copy and records the
    // response that a dequeue must produce.
    function automatic void apply_request(input t_request r);
        t_entry  e;
        t_result res;
        case (r.kind)
            K_ENQUEUE: begin
                e.special_op    = r.special_op;
                e.bus_addr      = 16'(r.start_addr) + 16'(r.stride) * 16'(r.channel)
                                + 16'(r.offset);
                e.offset        = r.offset;
                e.reg_num       = r.reg_num;
                e.func_code     = r.func_code;
                e.word_count    = r.word_count;
                e.write_data    = r.write_data;
                e.requester_tag = r.requester_tag;
                if (!r.prio && low_fill >= int'(low_allowance)) begin
                    low_head = 0;
                    low_fill = 0;
                    low_flushes++;
                end
                if (r.prio) begin
                    if (high_fill >= HighDepth) begin
                        high_head = 0;
                        high_fill = 0;
                        high_flushes++;
                    end
                    high_slots[(high_head + high_fill) % HighDepth] = e;
                    high_fill++;
                end else begin
                    if (low_fill >= LowDepth) begin
                        low_head = 0;
                        low_fill = 0;
                        low_flushes++;
                    end
                    low_slots[(low_head + low_fill) % LowDepth] = e;
                    low_fill++;
                end
            end
            K_PURGE: begin
                if (r.prio) begin
                    high_head = 0;
                    high_fill = 0;
                end else begin
                    low_head = 0;
                    low_fill = 0;
                end
            end
            K_DEQUEUE: begin
                res = '0;
                if (high_fill > 0) begin
                    res.found     = 1'b1;
                    res.from_high = 1'b1;
                    res.entry     = high_slots[high_head];
                    high_head     = (high_head + 1) % HighDepth;
                    high_fill--;
                end else if (low_fill > 0) begin
                    res.found = 1'b1;
                    res.entry = low_slots[low_head];
                    low_head  = (low_head + 1) % LowDepth;
                    low_fill--;
                end
                res.low_purges  = low_flushes;
                res.high_purges = high_flushes;
                expected_responses.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Driver: request and response-ready change on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (!req_busy) begin
                if (req_wait > 0) begin
                    req_wait--;
                    req_if.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    driven_request = pending_requests.pop_front();
                    req_if.kind          <= driven_request.kind;
                    req_if.priority_req  <= driven_request.prio;
                    req_if.special_op    <= driven_request.special_op;
                    req_if.start_addr    <= driven_request.start_addr;
                    req_if.channel       <= driven_request.channel;
                    req_if.stride        <= driven_request.stride;
                    req_if.offset        <= driven_request.offset;
                    req_if.reg_num       <= driven_request.reg_num;
                    req_if.func_code     <= driven_request.func_code;
                    req_if.word_count    <= driven_request.word_count;
                    req_if.write_data    <= driven_request.write_data;
                    req_if.requester_tag <= driven_request.requester_tag;
                    req_if.valid         <= 1'b1;
                    req_busy = 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            if (rsp_wait > 0) begin
                rsp_wait--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: handshakes are sampled on the rising edge.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                apply_request(driven_request);
                req_busy = 1'b0;
                req_wait = draw_wait(req_calm);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_responses.size() == 0) begin
                    $error("response word with no dequeue outstanding");
                    error_count++;
                end else begin
                    next_response = expected_responses.pop_front();
                    check_field("found", 32'(next_response.found), 32'(rsp_if.found));
                    check_field("from_high", 32'(next_response.from_high),
                                32'(rsp_if.from_high));
                    check_field("out_special_op", 32'(next_response.entry.special_op),
                                32'(rsp_if.out_special_op));
                    check_field("bus_addr", 32'(next_response.entry.bus_addr),
                                32'(rsp_if.bus_addr));
                    check_field("out_offset", 32'(next_response.entry.offset),
                                32'(rsp_if.out_offset));
                    check_field("out_reg_num", 32'(next_response.entry.reg_num),
                                32'(rsp_if.out_reg_num));
                    check_field("out_func_code", 32'(next_response.entry.func_code),
                                32'(rsp_if.out_func_code));
                    check_field("out_word_count", 32'(next_response.entry.word_count),
                                32'(rsp_if.out_word_count));
                    check_field("out_write_data", next_response.entry.write_data,
                                rsp_if.out_write_data);
                    check_field("out_requester_tag", next_response.entry.requester_tag,
                                rsp_if.out_requester_tag);
                    check_field("low_purges", 32'(next_response.low_purges),
                                32'(rsp_if.low_purges));
                    check_field("high_purges", 32'(next_response.high_purges),
                                32'(rsp_if.high_purges));
                end
                rsp_wait = draw_wait(rsp_calm);
            end
        end
    end

    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || req_busy || expected_responses.size() != 0)
            @(negedge i_clk);
        // Enqueues leave no response, so give the last one time to land.
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_allowance(input logic [5:0] value);
        @(negedge i_clk);
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        low_allowance = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_random_phase(input int target);
        int   counted;
        int   run;
        int   pick;
        logic prio;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            prio = 1'($urandom_range(0, 1));
            run  = $urandom_range(1, 40);
            if (pick < 35) begin
                // Long enqueue bursts run a queue into its flush points.
                repeat (run) pending_requests.push_back(make_request(K_ENQUEUE, prio));
                counted += run;
            end else if (pick < 62) begin
                repeat (run) pending_requests.push_back(make_request(K_DEQUEUE, prio));
                counted += run;
            end else if (pick < 88) begin
                run = $urandom_range(1, 8);
                repeat (run)
                    pending_requests.push_back(make_request(
                        $urandom_range(0, 1) ? K_ENQUEUE : K_DEQUEUE,
                        1'($urandom_range(0, 1))));
                counted += run;
            end else if (pick < 96) begin
                pending_requests.push_back(make_request(K_PURGE, prio));
                counted++;
            end else begin
                pending_requests.push_back(make_request(KindUnused, prio));
            end
        end
    endtask

    task automatic queue_directed();
        t_request r;
        pending_requests.push_back(make_request(K_DEQUEUE, 1'b0));
        // Every field but word_count at its top value; the address wraps past 16 bits.
        r               = make_request(K_ENQUEUE, 1'b1);
        r.special_op    = '1;
        r.start_addr    = '1;
        r.channel       = '1;
        r.stride        = '1;
        r.offset        = '1;
        r.reg_num       = '1;
        r.func_code     = '1;
        r.word_count    = 7'd125;
        r.write_data    = '1;
        r.requester_tag = '1;
        pending_requests.push_back(r);
        r      = '0;
        r.kind = K_ENQUEUE;
        pending_requests.push_back(r);
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b0));
        repeat (4) pending_requests.push_back(make_request(K_DEQUEUE, 1'b0));
        // Purges empty both queues without touching the counters.
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b1));
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b0));
        pending_requests.push_back(make_request(K_PURGE, 1'b1));
        pending_requests.push_back(make_request(K_PURGE, 1'b0));
        pending_requests.push_back(make_request(K_DEQUEUE, 1'b1));
        // The unused kind code must leave the queues alone.
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b0));
        pending_requests.push_back(make_request(KindUnused, 1'b1));
        pending_requests.push_back(make_request(KindUnused, 1'b0));
        pending_requests.push_back(make_request(K_DEQUEUE, 1'b0));
        // A high word enqueued after a low one still leaves first.
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b0));
        pending_requests.push_back(make_request(K_ENQUEUE, 1'b1));
        repeat (3) pending_requests.push_back(make_request(K_DEQUEUE, 1'b0));
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = '0;
        req_if.priority_req  = 1'b0;
        req_if.special_op    = '0;
        req_if.start_addr    = '0;
        req_if.channel       = '0;
        req_if.stride        = '0;
        req_if.offset        = '0;
        req_if.reg_num       = '0;
        req_if.func_code     = '0;
        req_if.word_count    = '0;
        req_if.write_data    = '0;
        req_if.requester_tag = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;

        high_head     = 0;
        high_fill     = 0;
        low_head      = 0;
        low_fill      = 0;
        low_flushes   = '0;
        high_flushes  = '0;
        low_allowance = AllowReset;
        req_busy      = 1'b0;
        req_wait      = 0;
        rsp_wait      = 0;
        req_calm      = 0;
        rsp_calm      = 0;
        error_count   = 0;
        cycle_count   = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        queue_random_phase(PhaseItems);
        wait_quiet();

        write_allowance(6'd0);
        queue_random_phase(PhaseItems);
        wait_quiet();

        write_allowance(6'd63);
        queue_random_phase(PhaseItems);
        wait_quiet();

        write_allowance(6'd1);
        queue_random_phase(PhaseItems);
        wait_quiet();

        write_allowance(6'($urandom_range(2, 31)));
        queue_random_phase(PhaseItems);
        wait_quiet();

        write_allowance(6'd32);
        queue_random_phase(PhaseItems);
        wait_quiet();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
